@@ hw/rtl/hbd_pkg.sv @@
// Shared types, stage map and constants of the height-field distance pipeline.
`timescale 1ns / 1ps
`default_nettype none

package hbd_pkg;

  // Pipeline depth and the register stage of each step
  localparam int NUM_STAGES = 15;
  localparam int ST_SCALE   = 1;   // coordinate times six
  localparam int ST_BIAS    = 2;   // integer part made non-negative
  localparam int ST_RECIP   = 3;   // quotient estimate by reciprocal
  localparam int ST_REM     = 4;   // raw remainder
  localparam int ST_FIX     = 5;   // corrected remainder and neighbor
  localparam int ST_ADDR    = 6;   // table addresses
  localparam int ST_MEM     = 7;   // table access
  localparam int ST_DIFF    = 8;   // sample differences
  localparam int ST_ROW     = 9;   // lerp along x
  localparam int ST_COLD    = 10;  // row difference
  localparam int ST_COL     = 11;  // lerp along z
  localparam int ST_ABS     = 12;  // sign and magnitude
  localparam int ST_MUL     = 13;  // height scale products
  localparam int ST_SUM     = 14;  // product sum and shift
  localparam int ST_OUT     = 15;  // subtract and saturate

  // Request kinds carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Field widths
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 10;
  localparam int ADDR_W  = 14;
  localparam int SAMPLE_W = 16;

  // Height table
  localparam int TABLE_DEPTH = 16384;
  localparam int NUM_BANKS   = 4;

  // round(0.000048 * 2^40), Q0.40
  localparam logic [25:0] SCALE_K = 26'd52776558;

  typedef logic [NUM_STAGES:1] stage_vec_t;

  // Wrapped column or row pair with the fraction of the coordinate
  typedef struct packed {
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [FRAC_W-1:0] frac;
  } wrap_out_t;

  // Table write request at the access stage
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] idx;
    logic [SAMPLE_W-1:0] value;
  } wr_req_t;

  // Four corner samples: s<row><col>, 0 = lower index, 1 = next index
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] s00;
    logic signed [SAMPLE_W-1:0] s01;
    logic signed [SAMPLE_W-1:0] s10;
    logic signed [SAMPLE_W-1:0] s11;
  } samples_t;

endpackage

`default_nettype wire

@@ hw/rtl/heightfield_bilinear_distance.sv @@
// Top level of the height-field distance engine: stream ports and pipeline control.
//
// Usage:
//   One input stream carries two request kinds, chosen by in_tuser. A write
//   request stores sample_value at sample_index of the height table and gives
//   no result. A query request gives one result on the output stream: point_y
//   minus the bilinearly sampled, scaled height under (point_x, point_z),
//   signed Q16.16, saturated.
//   A query's result appears with out_tvalid once the query has passed
//   through every stage up to the output stage.
//   Throughput: one request per cycle while in_tready is high, writes and
//   queries mixed in any order; a query sees every write accepted before it.
//   The height table has no reset; a query that touches an entry never
//   written returns an unspecified distance.
//   Reset clears the stage valid bits only.
//   Stall: when out_tready is low the result holds on out_tdata; stages
//   behind it keep filling empty slots, and in_tready falls only once every
//   stage from the input to the output holds a request.
`timescale 1ns / 1ps
`default_nettype none

module heightfield_bilinear_distance #(
  parameter int MAP_WIDTH  = 128,
  parameter int MAP_HEIGHT = 128
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [13:0] sample_index, [29:14] sample_value, [61:30] point_x,
  // [93:62] point_y, [125:94] point_z, [127:126] zero
  input  wire logic [127:0] in_tdata,
  // [0] op
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] distance
  output logic [31:0]       out_tdata
);

  localparam int NS = hbd_pkg::NUM_STAGES;
  localparam hbd_pkg::stage_vec_t ALL_V = '1;

  // Fields that travel beside the arithmetic
  typedef struct packed {
    logic        op;
    logic [13:0] widx;
    logic [15:0] wval;
    logic [31:0] y;
    logic [15:0] fx;
    logic [15:0] fz;
  } side_t;

  hbd_pkg::stage_vec_t v_r, v_nxt, adv;
  side_t side_r   [1:NS];
  side_t side_nxt [1:NS];
  hbd_pkg::wrap_out_t col_w, row_w;
  hbd_pkg::wr_req_t wr;
  hbd_pkg::samples_t samp;
  logic signed [31:0] distance;

  // A stage advances when some stage at or after it is empty or the output drains
  for (genvar k = 1; k <= NS; k++) begin : g_adv
    assign adv[k] = out_tready | ((v_r >> (k - 1)) != (ALL_V >> (k - 1)));
  end

  assign in_tready = adv[1];

  // Valid bits; drop write requests after the table access
  always_comb begin
    v_nxt[1] = in_tvalid;
    for (int k = 2; k <= NS; k++) begin
      v_nxt[k] = v_r[k-1];
    end
    v_nxt[hbd_pkg::ST_DIFF] = v_r[hbd_pkg::ST_MEM] &&
                              (side_r[hbd_pkg::ST_MEM].op == hbd_pkg::OP_QUERY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  // Side fields: load from the input, pick up fractions after the wrap
  always_comb begin
    side_nxt[1].op   = in_tuser;
    side_nxt[1].widx = in_tdata[13:0];
    side_nxt[1].wval = in_tdata[29:14];
    side_nxt[1].y    = in_tdata[93:62];
    side_nxt[1].fx   = '0;
    side_nxt[1].fz   = '0;
    for (int k = 2; k <= NS; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    side_nxt[hbd_pkg::ST_ADDR].fx = col_w.frac;
    side_nxt[hbd_pkg::ST_ADDR].fz = row_w.frac;
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NS; k++) begin
      if (adv[k]) begin
        side_r[k] <= side_nxt[k];
      end
    end
  end

  // Column index from x, row index from z
  hbd_wrap #(
    .MODULUS(MAP_WIDTH - 1)
  ) u_wrap_x (
    .clk  (clk),
    .adv  (adv),
    .coord($signed(in_tdata[61:30])),
    .wrap (col_w)
  );

  hbd_wrap #(
    .MODULUS(MAP_HEIGHT - 1)
  ) u_wrap_z (
    .clk  (clk),
    .adv  (adv),
    .coord($signed(in_tdata[125:94])),
    .wrap (row_w)
  );

  // Table write for a write request at the access stage
  assign wr.we    = v_r[hbd_pkg::ST_ADDR] &&
                    (side_r[hbd_pkg::ST_ADDR].op == hbd_pkg::OP_WRITE);
  assign wr.idx   = side_r[hbd_pkg::ST_ADDR].widx;
  assign wr.value = side_r[hbd_pkg::ST_ADDR].wval;

  hbd_fetch #(
    .MAP_WIDTH(MAP_WIDTH)
  ) u_fetch (
    .clk (clk),
    .adv (adv),
    .col (col_w),
    .row (row_w),
    .wr  (wr),
    .samp(samp)
  );

  hbd_interp u_interp (
    .clk     (clk),
    .adv     (adv),
    .samp    (samp),
    .fx      (side_r[hbd_pkg::ST_DIFF].fx),
    .fz      (side_r[hbd_pkg::ST_COLD].fz),
    .point_y ($signed(side_r[hbd_pkg::ST_SUM].y)),
    .distance(distance)
  );

  assign out_tvalid = v_r[NS];
  assign out_tdata  = distance;

endmodule

`default_nettype wire

@@ hw/rtl/hbd_wrap.sv @@
// Coordinate scale, floor split and floor modulo wrap over five stages.
`timescale 1ns / 1ps
`default_nettype none

module hbd_wrap #(
  parameter int MODULUS = 127
) (
  input  wire logic                clk,
  input  wire hbd_pkg::stage_vec_t adv,
  input  wire logic signed [31:0]  coord,
  output hbd_pkg::wrap_out_t       wrap
);

  // Bias is a multiple of the modulus that makes any integer part non-negative
  localparam int BIAS = MODULUS * (((2 ** 18) + MODULUS - 1) / MODULUS);
  localparam logic [20:0] RECIP = 21'((2 ** 20) / MODULUS);
  localparam logic [10:0] MOD_V = 11'(MODULUS);
  localparam logic [hbd_pkg::IDX_W-1:0] LAST_IDX = hbd_pkg::IDX_W'(MODULUS - 1);

  logic signed [34:0] scaled_r, scaled_nxt;
  logic [20:0] u_sum;
  logic [19:0] u_r;
  logic [15:0] frac2_r, frac3_r, frac4_r;
  logic [40:0] prod;
  logic [19:0] q_r, u3_r;
  logic [29:0] qm;
  logic [19:0] diff;
  logic [10:0] rem_r, rem_fix;
  logic [hbd_pkg::IDX_W-1:0] lo_nxt, hi_nxt;
  hbd_pkg::wrap_out_t wrap_r;

  // Scale by six as two shifted adds
  assign scaled_nxt = $signed({coord[31], coord, 2'b00}) +
                      $signed({{2{coord[31]}}, coord, 1'b0});

  // Floor integer part plus bias
  assign u_sum = {{2{scaled_r[34]}}, scaled_r[34:16]} + 21'(BIAS);

  // Quotient estimate, low by at most one
  assign prod = 41'(u_r) * 41'(RECIP);

  // Remainder lies below twice the modulus
  assign qm   = 30'(q_r) * 30'(MOD_V);
  assign diff = u3_r - qm[19:0];

  // Correct remainder and wrap the next index
  assign rem_fix = (rem_r >= MOD_V) ? (rem_r - MOD_V) : rem_r;
  assign lo_nxt  = rem_fix[hbd_pkg::IDX_W-1:0];
  assign hi_nxt  = (lo_nxt == LAST_IDX) ? '0 : (lo_nxt + 1'b1);

  always_ff @(posedge clk) begin
    if (adv[hbd_pkg::ST_SCALE]) begin
      scaled_r <= scaled_nxt;
    end
    if (adv[hbd_pkg::ST_BIAS]) begin
      u_r     <= u_sum[19:0];
      frac2_r <= scaled_r[15:0];
    end
    if (adv[hbd_pkg::ST_RECIP]) begin
      q_r     <= prod[39:20];
      u3_r    <= u_r;
      frac3_r <= frac2_r;
    end
    if (adv[hbd_pkg::ST_REM]) begin
      rem_r   <= diff[10:0];
      frac4_r <= frac3_r;
    end
    if (adv[hbd_pkg::ST_FIX]) begin
      wrap_r.lo   <= lo_nxt;
      wrap_r.hi   <= hi_nxt;
      wrap_r.frac <= frac4_r;
    end
  end

  assign wrap = wrap_r;

endmodule

`default_nettype wire

@@ hw/rtl/hbd_fetch.sv @@
// Table address generation and four-copy height table access.
`timescale 1ns / 1ps
`default_nettype none

module hbd_fetch #(
  parameter int MAP_WIDTH = 128
) (
  input  wire logic                clk,
  input  wire hbd_pkg::stage_vec_t adv,
  input  wire hbd_pkg::wrap_out_t  col,
  input  wire hbd_pkg::wrap_out_t  row,
  input  wire hbd_pkg::wr_req_t    wr,
  output hbd_pkg::samples_t        samp
);

  localparam logic [hbd_pkg::ADDR_W-1:0] WIDTH_V = hbd_pkg::ADDR_W'(MAP_WIDTH);

  logic [hbd_pkg::ADDR_W-1:0] col_lo_off, col_hi_off;
  logic [hbd_pkg::ADDR_W-1:0] addr_nxt [hbd_pkg::NUM_BANKS];
  logic [hbd_pkg::ADDR_W-1:0] addr_r   [hbd_pkg::NUM_BANKS];
  logic [hbd_pkg::SAMPLE_W-1:0] mem [hbd_pkg::NUM_BANKS][hbd_pkg::TABLE_DEPTH];
  logic [hbd_pkg::SAMPLE_W-1:0] rd_r [hbd_pkg::NUM_BANKS];

  // Column offsets, low bits only since the address wraps
  assign col_lo_off = hbd_pkg::ADDR_W'(col.lo) * WIDTH_V;
  assign col_hi_off = hbd_pkg::ADDR_W'(col.hi) * WIDTH_V;

  // One address per corner, one table copy per corner
  assign addr_nxt[0] = hbd_pkg::ADDR_W'(row.lo) + col_lo_off;
  assign addr_nxt[1] = hbd_pkg::ADDR_W'(row.lo) + col_hi_off;
  assign addr_nxt[2] = hbd_pkg::ADDR_W'(row.hi) + col_lo_off;
  assign addr_nxt[3] = hbd_pkg::ADDR_W'(row.hi) + col_hi_off;

  always_ff @(posedge clk) begin
    if (adv[hbd_pkg::ST_ADDR]) begin
      for (int b = 0; b < hbd_pkg::NUM_BANKS; b++) begin
        addr_r[b] <= addr_nxt[b];
      end
    end
  end

  // Write every copy, read each copy at its own corner
  always_ff @(posedge clk) begin
    if (adv[hbd_pkg::ST_MEM]) begin
      for (int b = 0; b < hbd_pkg::NUM_BANKS; b++) begin
        if (wr.we) begin
          mem[b][wr.idx] <= wr.value;
        end
        rd_r[b] <= mem[b][addr_r[b]];
      end
    end
  end

  assign samp.s00 = rd_r[0];
  assign samp.s01 = rd_r[1];
  assign samp.s10 = rd_r[2];
  assign samp.s11 = rd_r[3];

endmodule

`default_nettype wire

@@ hw/rtl/hbd_interp.sv @@
// Bilinear interpolation, height scaling and saturated distance over eight stages.
`timescale 1ns / 1ps
`default_nettype none

module hbd_interp (
  input  wire logic                clk,
  input  wire hbd_pkg::stage_vec_t adv,
  input  wire hbd_pkg::samples_t   samp,
  input  wire logic [15:0]         fx,
  input  wire logic [15:0]         fz,
  input  wire logic signed [31:0]  point_y,
  output logic signed [31:0]       distance
);

  logic signed [15:0] a_r, c_r;
  logic signed [16:0] dab_r, dcd_r;
  logic signed [16:0] fx_s, fz_s;
  logic signed [33:0] prod_top, prod_bot, sum_top, sum_bot;
  logic signed [31:0] top_r, bot_r, top10_r;
  logic signed [32:0] dtb_r;
  logic signed [49:0] prod_col, sum_col;
  logic signed [47:0] i_r;
  logic [47:0] mag_nxt, mag_r;
  logic neg12_r, neg13_r, neg14_r;
  logic [49:0] ph_r, pl_r;
  logic [50:0] psum;
  logic [18:0] q_r;
  logic [19:0] h_mag, h_val;
  logic signed [33:0] diff;
  logic signed [31:0] dist_nxt, dist_r;

  // Lerp along x
  assign fx_s     = $signed({1'b0, fx});
  assign prod_top = dab_r * fx_s;
  assign prod_bot = dcd_r * fx_s;
  assign sum_top  = prod_top + $signed({{2{a_r[15]}}, a_r, 16'h0000});
  assign sum_bot  = prod_bot + $signed({{2{c_r[15]}}, c_r, 16'h0000});

  // Lerp along z
  assign fz_s     = $signed({1'b0, fz});
  assign prod_col = dtb_r * fz_s;
  assign sum_col  = prod_col + $signed({{2{top10_r[31]}}, top10_r, 16'h0000});

  // Magnitude for truncation toward zero
  assign mag_nxt = i_r[47] ? (~i_r + 48'd1) : i_r;

  // Recombine the split product and drop 56 fraction bits
  assign psum = 51'(ph_r) + 51'(pl_r[49:24]);

  // Subtract height from y and saturate
  assign h_mag = {1'b0, q_r};
  assign h_val = neg14_r ? (~h_mag + 20'd1) : h_mag;
  assign diff  = $signed({{2{point_y[31]}}, point_y}) - $signed({{14{h_val[19]}}, h_val});

  always_comb begin
    if (diff[33:31] == 3'b000 || diff[33:31] == 3'b111) begin
      dist_nxt = diff[31:0];
    end else if (diff[33]) begin
      dist_nxt = 32'sh8000_0000;
    end else begin
      dist_nxt = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[hbd_pkg::ST_DIFF]) begin
      a_r   <= samp.s00;
      c_r   <= samp.s10;
      dab_r <= {samp.s01[15], samp.s01} - {samp.s00[15], samp.s00};
      dcd_r <= {samp.s11[15], samp.s11} - {samp.s10[15], samp.s10};
    end
    if (adv[hbd_pkg::ST_ROW]) begin
      top_r <= sum_top[31:0];
      bot_r <= sum_bot[31:0];
    end
    if (adv[hbd_pkg::ST_COLD]) begin
      top10_r <= top_r;
      dtb_r   <= {bot_r[31], bot_r} - {top_r[31], top_r};
    end
    if (adv[hbd_pkg::ST_COL]) begin
      i_r <= sum_col[47:0];
    end
    if (adv[hbd_pkg::ST_ABS]) begin
      mag_r   <= mag_nxt;
      neg12_r <= i_r[47];
    end
    if (adv[hbd_pkg::ST_MUL]) begin
      ph_r    <= 50'(mag_r[47:24]) * 50'(hbd_pkg::SCALE_K);
      pl_r    <= 50'(mag_r[23:0]) * 50'(hbd_pkg::SCALE_K);
      neg13_r <= neg12_r;
    end
    if (adv[hbd_pkg::ST_SUM]) begin
      q_r     <= psum[50:32];
      neg14_r <= neg13_r;
    end
    if (adv[hbd_pkg::ST_OUT]) begin
      dist_r <= dist_nxt;
    end
  end

  assign distance = dist_r;

endmodule

`default_nettype wire
